@@ design/stt_pkg.sv @@
package stt_pkg;

    // Field widths
    localparam int OFFSET_BITS  = 32;
    localparam int LENGTH_BITS  = 12;
    localparam int LINE_BITS    = 16;
    localparam int PREFIX_CHARS = 6;
    localparam int PIDX_BITS    = $clog2(PREFIX_CHARS);

    // Keyword table: sixteen words of at most six characters
    localparam int KW_COUNT = 16;
    localparam int KW_CHARS = 6;

    // Token queue (power of two, room for three pushes per beat)
    localparam int QDEPTH     = 8;
    localparam int QIDX_BITS  = $clog2(QDEPTH);
    localparam int QCNT_BITS  = QIDX_BITS + 1;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX  = {LENGTH_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};

    // Token kinds
    localparam logic [5:0] K_LPAREN   = 6'd0;
    localparam logic [5:0] K_RPAREN   = 6'd1;
    localparam logic [5:0] K_LBRACE   = 6'd2;
    localparam logic [5:0] K_RBRACE   = 6'd3;
    localparam logic [5:0] K_COMMA    = 6'd4;
    localparam logic [5:0] K_MINUS    = 6'd5;
    localparam logic [5:0] K_PLUS     = 6'd6;
    localparam logic [5:0] K_SEMI     = 6'd7;
    localparam logic [5:0] K_SLASH    = 6'd8;
    localparam logic [5:0] K_STAR     = 6'd9;
    localparam logic [5:0] K_BANG     = 6'd10;
    localparam logic [5:0] K_BANG_EQ  = 6'd11;
    localparam logic [5:0] K_EQUAL    = 6'd12;
    localparam logic [5:0] K_EQUAL_EQ = 6'd13;
    localparam logic [5:0] K_GREATER  = 6'd14;
    localparam logic [5:0] K_GREATER_EQ = 6'd15;
    localparam logic [5:0] K_LESS     = 6'd16;
    localparam logic [5:0] K_LESS_EQ  = 6'd17;
    localparam logic [5:0] K_IDENT    = 6'd18;
    localparam logic [5:0] K_STRING   = 6'd19;
    localparam logic [5:0] K_NUMBER   = 6'd20;
    localparam logic [5:0] K_KW0      = 6'd21;
    localparam logic [5:0] K_ERROR    = 6'd37;
    localparam logic [5:0] K_EOF      = 6'd38;

    // Error kinds
    localparam logic [1:0] E_NONE   = 2'd0;
    localparam logic [1:0] E_STRING = 2'd1;
    localparam logic [1:0] E_CHAR   = 2'd2;

    // Keywords, left-aligned and padded with spaces
    localparam logic [KW_CHARS*8-1:0] KW_TEXT [KW_COUNT] = '{
        "and   ", "class ", "else  ", "false ", "for   ", "fun   ",
        "if    ", "nil   ", "or    ", "print ", "return", "super ",
        "this  ", "true  ", "var   ", "while "
    };
    localparam int KW_LEN [KW_COUNT] = '{3, 5, 4, 5, 3, 3, 2, 3, 2, 5, 6, 5, 4, 4, 3, 5};

    typedef logic [PREFIX_CHARS-1:0][7:0] prefix_t;

    typedef struct packed {
        logic [5:0]             kind;
        logic [1:0]             err;
        logic [OFFSET_BITS-1:0] offset;
        logic [LENGTH_BITS-1:0] length;
        logic [LINE_BITS-1:0]   line;
        logic                   last;
    } token_t;

    // Up to three tokens per source beat, packed from entry 0
    typedef struct packed {
        logic [1:0]      n;
        token_t [2:0]    tok;
    } push_t;

    function automatic token_t mk_tok(
        input logic [5:0]             kind,
        input logic [1:0]             err,
        input logic [OFFSET_BITS-1:0] offset,
        input logic [LENGTH_BITS-1:0] length,
        input logic [LINE_BITS-1:0]   line
    );
        token_t t;
        t.kind   = kind;
        t.err    = err;
        t.offset = offset;
        t.length = length;
        t.line   = line;
        t.last   = 1'b0;
        return t;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // Identifier or keyword, from the stored prefix and the length
    function automatic logic [5:0] ident_kind(
        input prefix_t                pfx,
        input logic [LENGTH_BITS-1:0] len
    );
        logic [5:0] kind;
        logic       same;
        kind = K_IDENT;
        for (int i = KW_COUNT - 1; i >= 0; i--) begin
            same = (len == LENGTH_BITS'(KW_LEN[i]));
            for (int j = 0; j < KW_CHARS; j++) begin
                if (j < KW_LEN[i] && pfx[j] != KW_TEXT[i][(KW_CHARS-1-j)*8 +: 8])
                    same = 1'b0;
            end
            if (same)
                kind = K_KW0 + 6'(i);
        end
        return kind;
    endfunction

endpackage

@@ design/stt_front.sv @@
module stt_front
    import stt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] chr,
    output push_t      push
);

    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_SLASH   = 4'd1;
    localparam logic [3:0] M_COMMENT = 4'd2;
    localparam logic [3:0] M_IDENT   = 4'd3;
    localparam logic [3:0] M_NUMBER  = 4'd4;
    localparam logic [3:0] M_NUMDOT  = 4'd5;
    localparam logic [3:0] M_FRAC    = 4'd6;
    localparam logic [3:0] M_STRING  = 4'd7;
    localparam logic [3:0] M_BANG    = 4'd8;
    localparam logic [3:0] M_EQUAL   = 4'd9;
    localparam logic [3:0] M_LESS    = 4'd10;
    localparam logic [3:0] M_GREATER = 4'd11;
    localparam logic [3:0] M_DONE    = 4'd12;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    logic [3:0]             mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] begin_reg, begin_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    prefix_t                prefix_reg;

    logic [LENGTH_BITS-1:0] len_inc, len_inc2;
    logic [LINE_BITS-1:0]   line_inc;
    logic [5:0]             op_kind;
    logic                   a_v, b_v, c_v;
    token_t                 tok_a, tok_b, tok_c;
    logic                   run_idle;
    logic                   start;
    logic [3:0]             start_mode;
    logic                   pfx_we;
    logic [PIDX_BITS-1:0]   pfx_idx;
    logic [1:0]             n;

    assign len_inc  = (len_reg == LEN_MAX) ? len_reg : len_reg + 1'b1;
    assign len_inc2 = (len_inc == LEN_MAX) ? len_inc : len_inc + 1'b1;
    assign line_inc = (line_reg == LINE_MAX) ? line_reg : line_reg + 1'b1;

    always_comb
    begin
        case (mode_reg)
            M_BANG:  op_kind = K_BANG;
            M_EQUAL: op_kind = K_EQUAL;
            M_LESS:  op_kind = K_LESS;
            default: op_kind = K_GREATER;
        endcase
    end

    always_comb
    begin
        mode_next  = mode_reg;
        begin_next = begin_reg;
        len_next   = len_reg;
        line_next  = line_reg;
        a_v        = 1'b0;
        b_v        = 1'b0;
        c_v        = 1'b0;
        tok_a      = mk_tok(K_EOF, E_NONE, begin_reg, '0, line_reg);
        tok_b      = mk_tok(K_ERROR, E_CHAR, pos_reg - 1'b1, LENGTH_BITS'(1), line_reg);
        tok_c      = mk_tok(K_ERROR, E_CHAR, pos_reg, LENGTH_BITS'(1), line_reg);
        run_idle   = 1'b0;
        start      = 1'b0;
        start_mode = M_IDLE;
        pfx_we     = 1'b0;
        pfx_idx    = len_reg[PIDX_BITS-1:0];

        case (mode_reg)
            M_DONE:
            begin
                a_v = 1'b1;
            end
            M_SLASH:
            begin
                if (chr == "/")
                    mode_next = M_COMMENT;
                else
                begin
                    a_v      = 1'b1;
                    tok_a    = mk_tok(K_SLASH, E_NONE, begin_reg, LENGTH_BITS'(1), line_reg);
                    run_idle = 1'b1;
                end
            end
            M_COMMENT:
            begin
                if (chr == CH_LF || chr == CH_NUL)
                    run_idle = 1'b1;
            end
            M_IDENT:
            begin
                if (is_alpha(chr) || is_digit(chr))
                begin
                    pfx_we   = (len_reg < LENGTH_BITS'(PREFIX_CHARS));
                    len_next = len_inc;
                end
                else
                begin
                    a_v      = 1'b1;
                    tok_a    = mk_tok(ident_kind(prefix_reg, len_reg), E_NONE, begin_reg,
                                      len_reg, line_reg);
                    run_idle = 1'b1;
                end
            end
            M_NUMBER:
            begin
                if (is_digit(chr))
                    len_next = len_inc;
                else if (chr == ".")
                    mode_next = M_NUMDOT;
                else
                begin
                    a_v      = 1'b1;
                    tok_a    = mk_tok(K_NUMBER, E_NONE, begin_reg, len_reg, line_reg);
                    run_idle = 1'b1;
                end
            end
            M_NUMDOT:
            begin
                if (is_digit(chr))
                begin
                    len_next  = len_inc2;
                    mode_next = M_FRAC;
                end
                else
                begin
                    // number ends before the dot, the dot is an error
                    a_v      = 1'b1;
                    b_v      = 1'b1;
                    tok_a    = mk_tok(K_NUMBER, E_NONE, begin_reg, len_reg, line_reg);
                    run_idle = 1'b1;
                end
            end
            M_FRAC:
            begin
                if (is_digit(chr))
                    len_next = len_inc;
                else
                begin
                    a_v      = 1'b1;
                    tok_a    = mk_tok(K_NUMBER, E_NONE, begin_reg, len_reg, line_reg);
                    run_idle = 1'b1;
                end
            end
            M_STRING:
            begin
                if (chr == CH_NUL)
                begin
                    a_v      = 1'b1;
                    tok_a    = mk_tok(K_ERROR, E_STRING, begin_reg, len_reg, line_reg);
                    run_idle = 1'b1;
                end
                else
                begin
                    len_next = len_inc;
                    if (chr == CH_LF)
                        line_next = line_inc;
                    if (chr == "\"")
                    begin
                        a_v       = 1'b1;
                        tok_a     = mk_tok(K_STRING, E_NONE, begin_reg, len_inc, line_reg);
                        mode_next = M_IDLE;
                    end
                end
            end
            M_BANG, M_EQUAL, M_LESS, M_GREATER:
            begin
                a_v = 1'b1;
                if (chr == "=")
                begin
                    tok_a     = mk_tok(op_kind + 6'd1, E_NONE, begin_reg, LENGTH_BITS'(2),
                                       line_reg);
                    mode_next = M_IDLE;
                end
                else
                begin
                    tok_a    = mk_tok(op_kind, E_NONE, begin_reg, LENGTH_BITS'(1), line_reg);
                    run_idle = 1'b1;
                end
            end
            default:
            begin
                run_idle = 1'b1;
            end
        endcase

        // Byte seen between tokens
        if (run_idle)
        begin
            mode_next = M_IDLE;
            if (chr == CH_NUL)
            begin
                begin_next = pos_reg;
                mode_next  = M_DONE;
                c_v        = 1'b1;
                tok_c      = mk_tok(K_EOF, E_NONE, pos_reg, '0, line_reg);
            end
            else if (chr == " " || chr == CH_TAB || chr == CH_CR)
            begin
                mode_next = M_IDLE;
            end
            else if (chr == CH_LF)
            begin
                line_next = line_inc;
            end
            else if (is_alpha(chr))
            begin
                start      = 1'b1;
                start_mode = M_IDENT;
                pfx_we     = 1'b1;
                pfx_idx    = '0;
            end
            else if (is_digit(chr))
            begin
                start      = 1'b1;
                start_mode = M_NUMBER;
            end
            else
            begin
                case (chr)
                    "(":  begin c_v = 1'b1; tok_c.kind = K_LPAREN; tok_c.err = E_NONE; end
                    ")":  begin c_v = 1'b1; tok_c.kind = K_RPAREN; tok_c.err = E_NONE; end
                    "{":  begin c_v = 1'b1; tok_c.kind = K_LBRACE; tok_c.err = E_NONE; end
                    "}":  begin c_v = 1'b1; tok_c.kind = K_RBRACE; tok_c.err = E_NONE; end
                    ",":  begin c_v = 1'b1; tok_c.kind = K_COMMA;  tok_c.err = E_NONE; end
                    "-":  begin c_v = 1'b1; tok_c.kind = K_MINUS;  tok_c.err = E_NONE; end
                    "+":  begin c_v = 1'b1; tok_c.kind = K_PLUS;   tok_c.err = E_NONE; end
                    ";":  begin c_v = 1'b1; tok_c.kind = K_SEMI;   tok_c.err = E_NONE; end
                    "*":  begin c_v = 1'b1; tok_c.kind = K_STAR;   tok_c.err = E_NONE; end
                    "/":  begin start = 1'b1; start_mode = M_SLASH;   end
                    "\"": begin start = 1'b1; start_mode = M_STRING;  end
                    "!":  begin start = 1'b1; start_mode = M_BANG;    end
                    "=":  begin start = 1'b1; start_mode = M_EQUAL;   end
                    "<":  begin start = 1'b1; start_mode = M_LESS;    end
                    ">":  begin start = 1'b1; start_mode = M_GREATER; end
                    default: c_v = 1'b1;
                endcase
            end
        end

        if (start)
        begin
            mode_next  = start_mode;
            begin_next = pos_reg;
            len_next   = LENGTH_BITS'(1);
        end
    end

    // Offset stops moving once the text has ended
    assign pos_next = (mode_next == M_DONE) ? pos_reg : pos_reg + 1'b1;

    // Pack the tokens from entry 0; b is only ever present together with a
    assign n = 2'(a_v) + 2'(b_v) + 2'(c_v);

    always_comb
    begin
        push.n          = accept ? n : 2'd0;
        push.tok[0]     = a_v ? tok_a : tok_c;
        push.tok[1]     = b_v ? tok_b : tok_c;
        push.tok[2]     = tok_c;
        push.tok[0].last = (n == 2'd1);
        push.tok[1].last = (n == 2'd2);
        push.tok[2].last = (n == 2'd3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            begin_reg <= '0;
            pos_reg   <= '0;
            len_reg   <= '0;
            line_reg  <= LINE_BITS'(1);
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            begin_reg <= begin_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            line_reg  <= line_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && pfx_we)
            prefix_reg[pfx_idx] <= chr;
    end

    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == M_DONE) |=> (mode_reg == M_DONE))
        else $error("scanner left end-of-text mode");

    a_done_one_eof: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode_reg == M_DONE) |->
            (push.n == 2'd1 && push.tok[0].kind == K_EOF && $stable(pos_reg)))
        else $error("beat after end of text did not give a single EOF");

    a_one_last: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n != 2'd0) |->
            ($countones({push.tok[2].last, push.tok[1].last, push.tok[0].last}) == 1))
        else $error("token group without exactly one last marker");

endmodule

@@ design/stt_queue.sv @@
module stt_queue
    import stt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  push_t  push,
    output logic   room,
    output logic   tok_valid,
    input  logic   tok_ready,
    output token_t tok
);

    token_t                 mem [QDEPTH];
    logic [QIDX_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QIDX_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0]   count_reg, count_next;
    logic                   out_valid_reg, out_valid_next;
    token_t                 out_reg;
    logic                   pop;

    // Room for a full group of three tokens
    assign room = (count_reg <= QCNT_BITS'(QDEPTH - 3));

    assign pop = (!out_valid_reg || tok_ready) && (count_reg != '0);

    assign wr_ptr_next    = wr_ptr_reg + QIDX_BITS'(push.n);
    assign rd_ptr_next    = rd_ptr_reg + QIDX_BITS'(pop);
    assign count_next     = count_reg + QCNT_BITS'(push.n) - QCNT_BITS'(pop);
    assign out_valid_next = pop ? 1'b1 : (tok_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (k < int'(push.n))
                mem[wr_ptr_reg + QIDX_BITS'(k)] <= push.tok[k];
        end
        if (pop)
            out_reg <= mem[rd_ptr_reg];
    end

    assign tok_valid = out_valid_reg;
    assign tok       = out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_BITS'(QDEPTH))
        else $error("token queue overfilled");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n != 2'd0) |-> room)
        else $error("tokens pushed without room");

    a_refill: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg && count_reg != '0) |=> out_valid_reg)
        else $error("output stage left empty while tokens wait");

endmodule

@@ design/source_text_tokenizer.sv @@
// Streaming lexical scanner: one source byte per beat in, tokens out.
// Source channel: chr with chr_valid / chr_ready; byte 0 ends the text.
// Token channel: token_kind, error_kind, token_offset, token_length,
//   line_number and last_of_run with token_valid / token_ready. A byte gives
//   zero to three tokens; last_of_run marks the final one of that byte.
// The scanner classifies each byte in the cycle it is accepted and pushes
// its tokens into an eight-entry queue; an output register drains the queue
// at one token per cycle while token_ready allows.
// A token is written into the queue when its byte is accepted, then moved
// into the output register, from which it is offered.
// Throughput: one byte per cycle while three queue entries are free (else
// chr_ready drops), one token per cycle out while token_ready is high.
// Receiver stall: tokens hold in the output register and queue; the source
// side keeps running until the queue is nearly full.
// Reset: offset 0, line 1, between tokens, queue empty. After the end of
// text every further byte is answered with one more EOF token.
module source_text_tokenizer
    import stt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   chr_valid,
    output logic                   chr_ready,
    input  logic [7:0]             chr,
    output logic                   token_valid,
    input  logic                   token_ready,
    output logic [5:0]             token_kind,
    output logic [1:0]             error_kind,
    output logic [OFFSET_BITS-1:0] token_offset,
    output logic [LENGTH_BITS-1:0] token_length,
    output logic [LINE_BITS-1:0]   line_number,
    output logic                   last_of_run
);

    push_t  push;
    token_t tok;
    logic   room;
    logic   accept;

    // Source beat taken only with room for a full group of tokens
    assign chr_ready = room;
    assign accept    = chr_valid && room;

    stt_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .chr    (chr),
        .push   (push)
    );

    stt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .tok_valid (token_valid),
        .tok_ready (token_ready),
        .tok       (tok)
    );

    assign token_kind   = tok.kind;
    assign error_kind   = tok.err;
    assign token_offset = tok.offset;
    assign token_length = tok.length;
    assign line_number  = tok.line;
    assign last_of_run  = tok.last;

endmodule
